@@ rtl/olpr_pkg.sv @@
package olpr_pkg;

    localparam int CMD_W    = 2;
    localparam int PLATE_W  = 64;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int OCC_W    = 6;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LISTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADPOS  = 3'd5;

    typedef struct packed {
        logic                mem_we;
        logic                wr_from_rd;
        logic                mem_re;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } t_dp_ctl;

endpackage

@@ rtl/olpr_datapath.sv @@
module olpr_datapath
    import olpr_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctl             i_ctl,
    input  logic [AW-1:0]       i_waddr,
    input  logic [AW-1:0]       i_raddr,
    input  logic [CW-1:0]       i_slot,
    input  logic [PLATE_W-1:0]  i_plate,
    input  logic                i_out_stall,
    output logic [CW-1:0]       o_count,
    output logic                o_out_busy,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [PLATE_W-1:0]  o_entry,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_last
);

    logic [PLATE_W-1:0] r_mem [CAPACITY];
    logic [PLATE_W-1:0] r_rdata;
    logic [PLATE_W-1:0] n_wdata;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]  r_slot;
    logic [PLATE_W-1:0] r_entry;
    logic [OCC_W-1:0]   r_occupancy;
    logic               r_last;
    logic               is_listed;

    assign n_wdata   = i_ctl.wr_from_rd ? r_rdata : i_plate;
    assign is_listed = (i_ctl.out_status == ST_LISTED);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_we) begin
            r_mem[i_waddr] <= n_wdata;
        end
        if (i_ctl.mem_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_comb begin
        priority if (i_ctl.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.cnt_dec) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        priority if (i_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_status    <= i_ctl.out_status;
            r_slot      <= is_listed ? SLOT_W'(i_slot) : '0;
            r_entry     <= is_listed ? r_rdata : '0;
            r_occupancy <= OCC_W'(n_count);
            r_last      <= i_ctl.out_last;
        end
    end

    assign o_count     = r_count;
    assign o_out_busy  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_entry     = r_entry;
    assign o_occupancy = r_occupancy;
    assign o_last      = r_last;

endmodule

@@ rtl/olpr_ctrl.sv @@
module olpr_ctrl
    import olpr_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [POS_W-1:0] i_position,
    output logic             o_in_stall,
    input  logic [CW-1:0]    i_count,
    input  logic             i_out_busy,
    output t_dp_ctl          o_ctl,
    output logic [AW-1:0]    o_waddr,
    output logic [AW-1:0]    o_raddr,
    output logic [CW-1:0]    o_slot
);

    localparam int WW = CW + POS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_LIST  = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_m1;
    logic [WW-1:0] pos_ext;
    logic [WW-1:0] cnt_ext;
    logic          accept;
    logic          is_full;
    logic          is_empty;

    assign o_in_stall = (r_state != S_IDLE) || i_out_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign idx_p1     = r_idx + CW'(1);
    assign idx_m1     = r_idx - CW'(1);
    assign pos_ext    = WW'(i_position);
    assign cnt_ext    = WW'(i_count);
    assign is_full    = (i_count == CW'(CAPACITY));
    assign is_empty   = (i_count == '0);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_ctl   = '0;
        o_waddr = '0;
        o_raddr = '0;
        o_slot  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_APPEND: begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                            if (is_full) begin
                                o_ctl.out_status = ST_FULL;
                            end else begin
                                o_ctl.mem_we     = 1'b1;
                                o_waddr          = i_count[AW-1:0];
                                o_ctl.cnt_inc    = 1'b1;
                                o_ctl.out_status = ST_ADDED;
                            end
                        end
                        CMD_REMOVE: begin
                            priority if (is_empty) begin
                                o_ctl.out_load   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_EMPTY;
                            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                                o_ctl.out_load   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_BADPOS;
                            end else if (pos_ext == cnt_ext) begin
                                o_ctl.cnt_dec    = 1'b1;
                                o_ctl.out_load   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_REMOVED;
                            end else begin
                                o_ctl.mem_re = 1'b1;
                                o_raddr      = pos_ext[AW-1:0];
                                n_idx        = pos_ext[CW-1:0];
                                n_state      = S_SHIFT;
                            end
                        end
                        CMD_LIST: begin
                            if (is_empty) begin
                                o_ctl.out_load   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = ST_EMPTY;
                            end else begin
                                o_ctl.mem_re = 1'b1;
                                o_raddr      = '0;
                                n_idx        = CW'(1);
                                n_state      = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                o_ctl.mem_we     = 1'b1;
                o_ctl.wr_from_rd = 1'b1;
                o_waddr          = idx_m1[AW-1:0];
                if (idx_p1 == i_count) begin
                    o_ctl.cnt_dec    = 1'b1;
                    o_ctl.out_load   = 1'b1;
                    o_ctl.out_last   = 1'b1;
                    o_ctl.out_status = ST_REMOVED;
                    n_state          = S_IDLE;
                end else begin
                    o_ctl.mem_re = 1'b1;
                    o_raddr      = idx_p1[AW-1:0];
                    n_idx        = idx_p1;
                end
            end
            S_LIST: begin
                if (!i_out_busy) begin
                    o_ctl.out_load   = 1'b1;
                    o_ctl.out_status = ST_LISTED;
                    o_slot           = r_idx;
                    if (r_idx == i_count) begin
                        o_ctl.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_ctl.mem_re = 1'b1;
                        o_raddr      = r_idx[AW-1:0];
                        n_idx        = idx_p1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_list_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_idx != '0 && r_idx <= i_count))
        else $error("list index out of range");

    a_shift_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx != '0 && r_idx < i_count))
        else $error("shift index out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> !i_out_busy)
        else $error("result loaded while output register held");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.cnt_inc |-> !is_full)
        else $error("append past capacity");

    a_shift_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && o_ctl.out_load) |=> (r_state == S_IDLE))
        else $error("shift did not return to idle");

endmodule

@@ rtl/ordered_list_positional_remove_core.sv @@
// Channel | Valid      | Stall       | Payload
// input   | i_in_valid | o_in_stall  | i_cmd, i_plate, i_position
// output  | o_out_valid| i_out_stall | o_status, o_slot, o_entry, o_occupancy, o_last
//
// Append, and a remove of the tail entry or a rejected command, load the result straight from the idle state.
// Remove at position p of n entries moves n - p entries through the slot memory,
// one read and one write per cycle.
// List emits one entry per cycle, while the output is not stalled, from the registered memory read.
// Reset clears the count and the controller; the slot memory is not cleared.
// An output stall holds the result register and pauses list and input accept.
module ordered_list_positional_remove_core
    import olpr_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [PLATE_W-1:0]  i_plate,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [PLATE_W-1:0]  o_entry,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_dp_ctl       ctl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [CW-1:0] slot;
    logic [CW-1:0] count;
    logic          out_busy;

    olpr_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .AW       (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .o_in_stall (o_in_stall),
        .i_count    (count),
        .i_out_busy (out_busy),
        .o_ctl      (ctl),
        .o_waddr    (waddr),
        .o_raddr    (raddr),
        .o_slot     (slot)
    );

    olpr_datapath #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .AW       (AW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_waddr     (waddr),
        .i_raddr     (raddr),
        .i_slot      (slot),
        .i_plate     (i_plate),
        .i_out_stall (i_out_stall),
        .o_count     (count),
        .o_out_busy  (out_busy),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_entry     (o_entry),
        .o_occupancy (o_occupancy),
        .o_last      (o_last)
    );

endmodule
